>>> src/rdb_pkg.sv
package rdb_pkg;

  localparam int unsigned DistW        = 32;
  localparam int unsigned DirW         = 32;
  localparam int unsigned PosW         = 32;
  localparam int unsigned WorldW       = 31;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned DivStages    = 8;
  localparam int unsigned StepsPerStage = 4;
  localparam int unsigned NumLanes     = 6;
  localparam int unsigned Latency      = DivStages + 2;

  localparam logic [DistW-1:0] DistSat = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BOX_LEFT     = 3'd0,
    CFG_BOX_RIGHT    = 3'd1,
    CFG_BOX_BOTTOM   = 3'd2,
    CFG_BOX_TOP      = 3'd3,
    CFG_WORLD_WIDTH  = 3'd4,
    CFG_WORLD_HEIGHT = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [DirW-1:0] dir_x;
    logic signed [DirW-1:0] dir_y;
  } in_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             no_hit;
    logic             inside_box;
    logic             outside_world;
  } out_t;

  // one candidate division: magnitude of (face - pos) over magnitude of dir
  typedef struct packed {
    logic            en;
    logic            sat;
    logic [PosW:0]   an;
    logic [DirW-1:0] ad;
  } div_in_t;

endpackage

>>> src/ray_distance_to_boundary_top.sv
// the done strobe follows the start beat through the valid pipe and the done register
// throughput: one item per cycle, busy_o never rises
// six candidate divisions run as radix-2 long division, four bits per stage over eight stages
// reset clears the valid pipe and the box and world registers to zero
// the receiver cannot stall, each result shows for exactly one cycle
module ray_distance_to_boundary_top
  import rdb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  in_t                data_i,
  output logic               done_o,
  output out_t               result_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DistW-1:0]   cfg_data_i
);

  typedef struct packed {
    div_in_t div;
    logic    low;
  } cand_t;

  typedef struct packed {
    logic low;
    logic in_box;
    logic outside;
  } side_t;

  // configuration registers
  logic signed [PosW-1:0] box_left_q, box_right_q, box_bottom_q, box_top_q;
  logic [WorldW-1:0]      world_width_q, world_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_left_q     <= '0;
      box_right_q    <= '0;
      box_bottom_q   <= '0;
      box_top_q      <= '0;
      world_width_q  <= '0;
      world_height_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BOX_LEFT:     box_left_q     <= cfg_data_i;
        CFG_BOX_RIGHT:    box_right_q    <= cfg_data_i;
        CFG_BOX_BOTTOM:   box_bottom_q   <= cfg_data_i;
        CFG_BOX_TOP:      box_top_q      <= cfg_data_i;
        CFG_WORLD_WIDTH:  world_width_q  <= cfg_data_i[WorldW-1:0];
        CFG_WORLD_HEIGHT: world_height_q <= cfg_data_i[WorldW-1:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // signed distance numerator and its classification; a candidate that is
  // zero or negative forces the minimum step, so only its flag is kept
  function automatic cand_t make_cand(input logic signed [PosW:0]   face,
                                      input logic signed [PosW-1:0] pos,
                                      input logic signed [DirW-1:0] dir,
                                      input logic                   en);
    logic signed [PosW+1:0] num;
    logic [PosW+1:0]        an_w;
    logic [DirW-1:0]        ad;
    logic                   pos_ok;
    cand_t                  c;
    num    = (PosW+2)'(face) - (PosW+2)'(pos);
    an_w   = num[PosW+1] ? (PosW+2)'(-num) : (PosW+2)'(num);
    ad     = dir[DirW-1] ? DirW'(-dir) : DirW'(dir);
    pos_ok = (num != '0) && (num[PosW+1] == dir[DirW-1]);
    c.div.an  = an_w[PosW:0];
    c.div.ad  = ad;
    c.div.sat = an_w >= {ad, 2'b00};
    c.div.en  = en && pos_ok;
    c.low     = en && !pos_ok;
    return c;
  endfunction

  cand_t cand [NumLanes];

  // per axis: the near box face, the far box face and the world edge ahead;
  // a zero direction component leaves all three lanes of its axis idle
  always_comb begin
    logic signed [PosW:0] bl, br, bb, bt, ww, wh, zero;
    bl   = (PosW+1)'(box_left_q);
    br   = (PosW+1)'(box_right_q);
    bb   = (PosW+1)'(box_bottom_q);
    bt   = (PosW+1)'(box_top_q);
    ww   = {2'b00, world_width_q};
    wh   = {2'b00, world_height_q};
    zero = '0;
    if (!data_i.dir_x[DirW-1] && data_i.dir_x != '0) begin
      cand[0] = make_cand(bl, data_i.pos_x, data_i.dir_x, data_i.pos_x < box_left_q);
      cand[1] = make_cand(br, data_i.pos_x, data_i.dir_x, data_i.pos_x < box_right_q);
      cand[2] = make_cand(ww, data_i.pos_x, data_i.dir_x, 1'b1);
    end else begin
      cand[0] = make_cand(br, data_i.pos_x, data_i.dir_x,
                          (data_i.dir_x != '0) && (data_i.pos_x > box_right_q));
      cand[1] = make_cand(bl, data_i.pos_x, data_i.dir_x,
                          (data_i.dir_x != '0) && (data_i.pos_x > box_left_q));
      cand[2] = make_cand(zero, data_i.pos_x, data_i.dir_x, data_i.dir_x != '0);
    end
    if (!data_i.dir_y[DirW-1] && data_i.dir_y != '0) begin
      cand[3] = make_cand(bb, data_i.pos_y, data_i.dir_y, data_i.pos_y < box_bottom_q);
      cand[4] = make_cand(bt, data_i.pos_y, data_i.dir_y, data_i.pos_y < box_top_q);
      cand[5] = make_cand(wh, data_i.pos_y, data_i.dir_y, 1'b1);
    end else begin
      cand[3] = make_cand(bt, data_i.pos_y, data_i.dir_y,
                          (data_i.dir_y != '0) && (data_i.pos_y > box_top_q));
      cand[4] = make_cand(bb, data_i.pos_y, data_i.dir_y,
                          (data_i.dir_y != '0) && (data_i.pos_y > box_bottom_q));
      cand[5] = make_cand(zero, data_i.pos_y, data_i.dir_y, data_i.dir_y != '0);
    end
  end

  // box and world tests, carried beside the division lanes
  side_t side_d;
  always_comb begin
    side_d.low = 1'b0;
    for (int i = 0; i < NumLanes; i++) begin
      side_d.low = side_d.low | cand[i].low;
    end
    side_d.in_box  = (data_i.pos_x >= box_left_q) && (data_i.pos_x <= box_right_q) &&
                     (data_i.pos_y >= box_bottom_q) && (data_i.pos_y <= box_top_q);
    side_d.outside = data_i.pos_x[PosW-1] || data_i.pos_y[PosW-1] ||
                     ((PosW+1)'(data_i.pos_x) > (PosW+1)'({2'b00, world_width_q})) ||
                     ((PosW+1)'(data_i.pos_y) > (PosW+1)'({2'b00, world_height_q}));
  end

  logic [DistW-1:0] quot [NumLanes];

  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    rdb_div_lane u_lane (
      .clk_i  (clk_i),
      .div_i  (cand[i].div),
      .quot_o (quot[i])
    );
  end

  // valid and side data track the lane stages one for one
  logic  vld_q  [DivStages+1];
  side_t side_q [DivStages+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= DivStages; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else begin
      vld_q[0] <= accept;
      for (int s = 1; s <= DivStages; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int s = 1; s <= DivStages; s++) begin
      side_q[s] <= side_q[s-1];
    end
  end

  // final stage: minimum over the lanes, then the minimum-step rule
  out_t out_d, out_q;
  logic done_q;

  always_comb begin
    logic [DistW-1:0] dmin;
    dmin = DistSat;
    for (int i = 0; i < NumLanes; i++) begin
      if (quot[i] < dmin) begin
        dmin = quot[i];
      end
    end
    if (side_q[DivStages].low || dmin == '0) begin
      out_d.distance = DistW'(1);
      out_d.no_hit   = 1'b0;
    end else begin
      out_d.distance = dmin;
      out_d.no_hit   = (dmin == DistSat);
    end
    out_d.inside_box    = side_q[DivStages].in_box;
    out_d.outside_world = side_q[DivStages].outside;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[DivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o   = done_q;
  assign result_o = out_q;

endmodule

>>> src/rdb_div_lane.sv
module rdb_div_lane
  import rdb_pkg::*;
(
  input  logic             clk_i,
  input  div_in_t          div_i,
  output logic [DistW-1:0] quot_o
);

  typedef struct packed {
    logic            en;
    logic            sat;
    logic [DirW-2:0] rem;
    logic [DistW-1:0] rest;
    logic [DistW-1:0] quot;
    logic [DirW-1:0] ad;
  } st_t;

  st_t st_q [DivStages+1];
  st_t st_d [DivStages+1];

  // input stage: top part of the shifted dividend is an >> 2
  always_comb begin
    st_d[0].en   = div_i.en;
    st_d[0].sat  = div_i.sat;
    st_d[0].rem  = div_i.an[PosW:2];
    st_d[0].rest = {div_i.an[1:0], {(DistW-2){1'b0}}};
    st_d[0].quot = '0;
    st_d[0].ad   = div_i.ad;
  end

  for (genvar s = 1; s <= DivStages; s++) begin : g_stage
    always_comb begin
      logic [DirW-1:0] trial;
      st_d[s] = st_q[s-1];
      for (int k = 0; k < StepsPerStage; k++) begin
        trial = {st_d[s].rem, st_d[s].rest[DistW-1]};
        st_d[s].rest = {st_d[s].rest[DistW-2:0], 1'b0};
        if (trial >= st_d[s].ad) begin
          st_d[s].rem  = trial[DirW-2:0] - st_d[s].ad[DirW-2:0];
          st_d[s].quot = {st_d[s].quot[DistW-2:0], 1'b1};
        end else begin
          st_d[s].rem  = trial[DirW-2:0];
          st_d[s].quot = {st_d[s].quot[DistW-2:0], 1'b0};
        end
      end
    end
  end

  for (genvar s = 0; s <= DivStages; s++) begin : g_reg
    always_ff @(posedge clk_i) begin
      st_q[s] <= st_d[s];
    end
  end

  assign quot_o = (!st_q[DivStages].en || st_q[DivStages].sat) ? DistSat
                                                               : st_q[DivStages].quot;

endmodule

>>> src/rdb_checker.sv
module rdb_checker
  import rdb_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input out_t result_o
);

  logic [3:0] up_q;

  // cycles since reset, saturating
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q <= '0;
    end else if (up_q != '1) begin
      up_q <= up_q + 4'd1;
    end
  end

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (up_q >= 4'(Latency)) |-> (done_o == $past(start_i && !busy_o, Latency)))
    else $error("done strobe does not follow start beat");

  a_min_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.distance != '0))
    else $error("distance below one step");

  a_nohit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.no_hit == (result_o.distance == DistSat)))
    else $error("no_hit disagrees with saturated distance");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised");

endmodule

bind ray_distance_to_boundary_top rdb_checker u_rdb_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .done_o   (done_o),
  .result_o (result_o)
);

>>> tb/sv/ray_distance_to_boundary_top_test.sv
module ray_distance_to_boundary_top_test;
  import rdb_pkg::*;

  // clock, reset and block ports
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  in_t                data_i = '0;
  logic               done_o;
  out_t               result_o;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [DistW-1:0]   cfg_data_i = '0;

  always #1 clk_i = ~clk_i;

  ray_distance_to_boundary_top u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .data_i,
    .done_o, .result_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // predictor copy of the box and world registers
  longint box_lo_x, box_hi_x, box_lo_y, box_hi_y, world_w, world_h;

  in_t  pending_beats[$];
  out_t expected_results[$];
  int   mismatches = 0;
  int   beats_sent = 0;
  int   results_seen = 0;
  int   hit_count = 0;
  int   nohit_count = 0;
  bit   stim_done = 1'b0;

  // sender burst state
  int   burst_left = 0;
  int   gap_left = 0;

  localparam longint Sat = 64'h0000_0000_FFFF_FFFF;

  // signed (face - pos) scaled by 2^30 over dir, truncated on magnitudes
  function automatic longint face_distance(longint face, longint pos, longint dir);
    longint num;
    longint unsigned mag_n, mag_d, quot;
    begin
      num   = face - pos;
      mag_n = (num < 0) ? -num : num;
      mag_d = (dir < 0) ? -dir : dir;
      quot  = (mag_n << 30) / mag_d;
      if ((num < 0) != (dir < 0)) begin
        return -longint'(quot);
      end
      return (quot > Sat) ? Sat : longint'(quot);
    end
  endfunction

  // nearest crossing ahead along one axis
  function automatic longint axis_nearest(longint dmin, longint p, longint d,
                                          longint lo, longint hi, longint wmax);
    longint c;
    begin
      if (d > 0) begin
        if (p < lo) begin
          c = face_distance(lo, p, d);
          if (c < dmin) dmin = c;
        end
        if (p < hi) begin
          c = face_distance(hi, p, d);
          if (c < dmin) dmin = c;
        end
        c = face_distance(wmax, p, d);
        if (c < dmin) dmin = c;
      end else if (d < 0) begin
        if (p > hi) begin
          c = face_distance(hi, p, d);
          if (c < dmin) dmin = c;
        end
        if (p > lo) begin
          c = face_distance(lo, p, d);
          if (c < dmin) dmin = c;
        end
        c = face_distance(0, p, d);
        if (c < dmin) dmin = c;
      end
      return dmin;
    end
  endfunction

  function automatic out_t boundary_result(in_t beat);
    longint x, y, dx, dy, dmin;
    out_t r;
    begin
      x  = longint'(beat.pos_x);
      y  = longint'(beat.pos_y);
      dx = longint'(beat.dir_x);
      dy = longint'(beat.dir_y);
      dmin = Sat;
      dmin = axis_nearest(dmin, x, dx, box_lo_x, box_hi_x, world_w);
      dmin = axis_nearest(dmin, y, dy, box_lo_y, box_hi_y, world_h);
      if (dmin <= 0) begin
        r.distance = 32'd1;
        r.no_hit   = 1'b0;
      end else begin
        r.distance = dmin[31:0];
        r.no_hit   = (dmin == Sat);
      end
      r.inside_box = (x >= box_lo_x && x <= box_hi_x && y >= box_lo_y && y <= box_hi_y);
      r.outside_world = (x < 0 || x > world_w || y < 0 || y > world_h);
      return r;
    end
  endfunction

  // register write while idle, mirrored into the predictor
  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    begin
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= value;
      case (idx)
        CFG_BOX_LEFT:     box_lo_x = longint'(signed'(value));
        CFG_BOX_RIGHT:    box_hi_x = longint'(signed'(value));
        CFG_BOX_BOTTOM:   box_lo_y = longint'(signed'(value));
        CFG_BOX_TOP:      box_hi_y = longint'(signed'(value));
        CFG_WORLD_WIDTH:  world_w  = longint'({1'b0, value[30:0]});
        CFG_WORLD_HEIGHT: world_h  = longint'({1'b0, value[30:0]});
        default: ;
      endcase
      @(negedge clk_i);
      cfg_we_i <= 1'b0;
    end
  endtask

  task automatic setup_geometry(logic [31:0] l, logic [31:0] r, logic [31:0] b,
                                logic [31:0] t, logic [31:0] w, logic [31:0] h);
    begin
      write_reg(CFG_BOX_LEFT, l);
      write_reg(CFG_BOX_RIGHT, r);
      write_reg(CFG_BOX_BOTTOM, b);
      write_reg(CFG_BOX_TOP, t);
      write_reg(CFG_WORLD_WIDTH, w);
      write_reg(CFG_WORLD_HEIGHT, h);
    end
  endtask

  // wait until every queued beat has gone and every result is back
  task automatic drain;
    begin
      while (pending_beats.size() != 0 || expected_results.size() != 0) begin
        @(posedge clk_i);
      end
      repeat (Latency + 4) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] any_dir();
    int sel;
    begin
      sel = $urandom_range(0, 9);
      case (sel)
        0: return 32'd0;
        1: return 32'h4000_0000;
        2: return 32'hC000_0000;
        3: return $urandom;                          // out of range components
        4: return $urandom_range(0, 15);
        5: return -$urandom_range(1, 15);
        default: return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
      endcase
    end
  endfunction

  // positions mostly near the world and box, sometimes anywhere
  function automatic logic [31:0] any_pos(longint span);
    begin
      if ($urandom_range(0, 7) == 0) return $urandom;
      return 32'(longint'($urandom_range(0, 32'(span))) - span / 8);
    end
  endfunction

  task automatic add_beat(logic [31:0] px, logic [31:0] py,
                          logic [31:0] dx, logic [31:0] dy);
    in_t b;
    begin
      b.pos_x = px;
      b.pos_y = py;
      b.dir_x = dx;
      b.dir_y = dy;
      pending_beats.push_back(b);
    end
  endtask

  task automatic random_phase(int count, longint span);
    begin
      repeat (count) add_beat(any_pos(span), any_pos(span), any_dir(), any_dir());
      drain();
    end
  endtask

  // stimulus: directed corners, then random phases under several geometries
  initial begin
    box_lo_x = 0; box_hi_x = 0; box_lo_y = 0; box_hi_y = 0; world_w = 0; world_h = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry: all-zero box and world
    add_beat(32'd0, 32'd0, 32'd0, 32'd0);                    // both directions zero
    add_beat(32'h0001_0000, 32'd0, 32'h4000_0000, 32'd0);    // beyond world edge ahead
    drain();

    setup_geometry(32'h0010_0000, 32'h0020_0000, 32'h0008_0000, 32'h0030_0000,
                   32'h0040_0000, 32'h0050_0000);
    add_beat(32'h0010_0000, 32'h0008_0000, 32'h4000_0000, 32'h4000_0000); // on box corner
    add_beat(32'h0020_0000, 32'h0030_0000, 32'hC000_0000, 32'hC000_0000);
    add_beat(32'h0015_0000, 32'h0010_0000, 32'h4000_0000, 32'd0);
    add_beat(32'h0015_0000, 32'h0010_0000, 32'd0, 32'hC000_0000);
    add_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hC000_0000, 32'hC000_0000);
    add_beat(32'h8000_0000, 32'h8000_0000, 32'h4000_0000, 32'h4000_0000);
    add_beat(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'hFFFF_FFFF);   // saturated quotients
    add_beat(32'h0040_0000, 32'h0050_0000, 32'h4000_0000, 32'h4000_0000); // on world edge
    add_beat(32'h0001_0000, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000); // beyond +-1.0
    add_beat(32'hFFFF_FFFF, 32'h0001_0000, 32'hC000_0000, 32'd0);
    add_beat(32'h0000_0000, 32'h0000_0000, 32'd0, 32'd0);
    drain();

    // inverted box with register extremes, world at its widest
    setup_geometry(32'h7FFF_FFFF, 32'h8000_0000, 32'h0030_0000, 32'h0008_0000,
                   32'hFFFF_FFFF, 32'h7FFF_FFFF);
    add_beat(32'h0010_0000, 32'h0010_0000, 32'h4000_0000, 32'hC000_0000);
    add_beat(32'h7FFF_FFFF, 32'h0000_0000, 32'hC000_0000, 32'h4000_0000);
    add_beat(32'h0020_0000, 32'h0020_0000, 32'h0000_1000, 32'hFFFF_F000);
    drain();
    random_phase(250, 64'h7FFF_FFFF);

    // ordinary box in a small world
    setup_geometry(32'h0004_0000, 32'h000C_0000, 32'h0002_0000, 32'h000A_0000,
                   32'h0010_0000, 32'h0010_0000);
    random_phase(350, 64'h0014_0000);

    // full-range box, medium world
    setup_geometry(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h0100_0000, 32'h0080_0000);
    random_phase(250, 64'h0120_0000);

    // random geometry, ordered box
    setup_geometry(32'h0000_0000 + $urandom_range(0, 32'h0010_0000),
                   32'h0010_0000 + $urandom_range(0, 32'h0010_0000),
                   32'h0000_0000 + $urandom_range(0, 32'h0010_0000),
                   32'h0010_0000 + $urandom_range(0, 32'h0010_0000),
                   $urandom, $urandom);
    random_phase(330, 64'h0030_0000);

    stim_done = 1'b1;
  end

  // driver: bursts of beats separated by random gaps, changes at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && pending_beats.size() != 0 && gap_left == 0) begin
      start_i <= 1'b1;
      data_i  <= pending_beats[0];
    end else begin
      start_i <= 1'b0;
      if (gap_left != 0) gap_left <= gap_left - 1;
    end
  end

  // acceptance of a start beat at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) begin
      expected_results.push_back(boundary_result(data_i));
      void'(pending_beats.pop_front());
      beats_sent <= beats_sent + 1;
      if (burst_left == 0) begin
        burst_left <= $urandom_range(0, 2) == 0 ? 200 : $urandom_range(1, 12);
        gap_left   <= $urandom_range(0, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // monitor: each done strobe is compared field by field with the oldest expectation
  always @(posedge clk_i) begin
    out_t exp_r;
    if (rst_ni && done_o) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("result with nothing expected: %p", result_o);
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.no_hit) nohit_count <= nohit_count + 1;
        else hit_count <= hit_count + 1;
        if (result_o.distance !== exp_r.distance || result_o.no_hit !== exp_r.no_hit ||
            result_o.inside_box !== exp_r.inside_box ||
            result_o.outside_world !== exp_r.outside_world) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) begin
            $display("mismatch: expected dist %h nohit %b in %b out %b",
                     exp_r.distance, exp_r.no_hit, exp_r.inside_box, exp_r.outside_world);
            $display("          actual   dist %h nohit %b in %b out %b",
                     result_o.distance, result_o.no_hit, result_o.inside_box,
                     result_o.outside_world);
          end
        end
      end
    end
  end

  // end of run once the stimulus has drained
  initial begin
    wait (stim_done);
    repeat (Latency + 4) @(posedge clk_i);
    $display("beats %0d, results %0d (%0d hits, %0d with no hit), five geometries",
             beats_sent, results_seen, hit_count, nohit_count);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ray_distance_to_boundary_top_test OK");
    end else begin
      $display("ray_distance_to_boundary_top_test NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200000;
    $display("ray_distance_to_boundary_top_test NOT OK");
    $finish;
  end

endmodule

>>> ray_distance_to_boundary_top.f
src/rdb_pkg.sv
src/rdb_div_lane.sv
src/ray_distance_to_boundary_top.sv
src/rdb_checker.sv
tb/sv/ray_distance_to_boundary_top_test.sv
